/* hw/rtl/lpmf_pkg.sv */
package lpmf_pkg;

  localparam int WORD_W   = 32;
  localparam int LEN_W    = 9;
  localparam int WCNT_W   = LEN_W - 1;
  localparam int STATUS_W = 3;

  // Byte lane select within a word
  localparam logic [1:0] LANE_MASK = 2'b11;

  localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_DROP = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POP_DATA  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POP_SMALL = 3'd4;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  typedef enum logic [1:0] {
    K_PUSH_FIRST = 2'd0,
    K_PUSH_DATA  = 2'd1,
    K_POP        = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [LEN_W-1:0]   byte_count;
    logic [WORD_W-1:0]  data_word;
  } lpmf_cmd_t;

  // Whole words needed for a byte length
  function automatic logic [WCNT_W-1:0] words_of(input logic [LEN_W-1:0] len);
    logic [LEN_W:0] s;
    s = {1'b0, len} + (LEN_W + 1)'(3);
    return s[LEN_W:2];
  endfunction

  // Keep only the valid low bytes of the final word
  function automatic logic [WORD_W-1:0] last_mask(input logic [LEN_W-1:0] len);
    logic [1:0] rem;
    rem = len[1:0] & LANE_MASK;
    case (rem)
      2'd1:    return 32'h0000_00FF;
      2'd2:    return 32'h0000_FFFF;
      2'd3:    return 32'h00FF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

/* hw/rtl/lpmf_ram.sv */
module lpmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/lpmf_front.sv */
module lpmf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic                         in_first_beat,
  input  logic [lpmf_pkg::LEN_W-1:0]   in_byte_count,
  input  logic [lpmf_pkg::WORD_W-1:0]  in_data_word,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output lpmf_pkg::lpmf_cmd_t          cmd
);

  import lpmf_pkg::*;

  lpmf_cmd_t            in_cmd;
  lpmf_cmd_t            q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [CMDQ_AW-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 push, pop;

  // Classify the word
  always_comb begin
    in_cmd.byte_count = in_byte_count;
    in_cmd.data_word  = in_data_word;
    if (in_opcode) begin
      in_cmd.kind = K_POP;
    end else if (in_first_beat) begin
      in_cmd.kind = K_PUSH_FIRST;
    end else begin
      in_cmd.kind = K_PUSH_DATA;
    end
  end

  assign in_ready  = (cnt_r != CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_idx_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign wr_idx_nxt = push ? wr_idx_r + 1'b1 : wr_idx_r;
  assign rd_idx_nxt = pop ? rd_idx_r + 1'b1 : rd_idx_r;
  assign cnt_nxt    = cnt_r + CMDQ_CW'(push) - CMDQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= in_cmd;
    end
  end

endmodule

/* hw/rtl/lpmf_back.sv */
module lpmf_back #(
  parameter int RING_WORDS        = 1024,
  parameter int MAX_MESSAGE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  lpmf_pkg::lpmf_cmd_t           cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpmf_pkg::STATUS_W-1:0] out_status,
  output logic [lpmf_pkg::WORD_W-1:0]   out_word,
  output logic [lpmf_pkg::LEN_W-1:0]    out_length,
  output logic                          out_last_word
);

  import lpmf_pkg::*;

  localparam int PTR_W = $clog2(RING_WORDS);
  localparam int CNT_W = $clog2(RING_WORDS + 1);
  localparam int CMP_W = (CNT_W > WCNT_W + 1) ? CNT_W : WCNT_W + 1;
  localparam int ADV_W = CMP_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_WORDS - 1);
  localparam logic [ADV_W-1:0] RING_SZ  = ADV_W'(RING_WORDS);
  localparam logic [CNT_W-1:0] RING_CNT = CNT_W'(RING_WORDS);
  localparam logic [12:0]      MAX_LEN  = 13'(MAX_MESSAGE_BYTES);

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_POP_CHK  = 3'b010,
    S_POP_DATA = 3'b100
  } state_t;

  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic             wrapped;
  } adv_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic adv_t ptr_adv(input logic [PTR_W-1:0] p, input logic [WCNT_W:0] n);
    logic [ADV_W-1:0] s;
    adv_t             r;
    s = ADV_W'(p) + ADV_W'(n);
    if (s >= RING_SZ) begin
      r.ptr     = PTR_W'(s - RING_SZ);
      r.wrapped = 1'b1;
    end else begin
      r.ptr     = PTR_W'(s);
      r.wrapped = 1'b0;
    end
    return r;
  endfunction

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic                wrap_r, wrap_nxt;
  logic [WCNT_W-1:0]   left_r, left_nxt;
  logic                dropping_r, dropping_nxt;
  logic [LEN_W-1:0]    hdr_len_r, hdr_len_nxt;
  logic [WCNT_W-1:0]   msg_words_r, msg_words_nxt;
  logic [PTR_W-1:0]    wr_pos_r, wr_pos_nxt;
  logic [PTR_W-1:0]    rd_pos_r, rd_pos_nxt;
  logic [WCNT_W-1:0]   pop_left_r, pop_left_nxt;
  logic [LEN_W-1:0]    pop_len_r, pop_len_nxt;
  logic [LEN_W-1:0]    pop_cap_r, pop_cap_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [LEN_W-1:0]    out_length_r;
  logic                out_last_r;

  logic                emit, emit_last;
  logic [STATUS_W-1:0] emit_status;
  logic [WORD_W-1:0]   emit_word;
  logic [LEN_W-1:0]    emit_length;

  logic                ram_we, ram_re;
  logic [PTR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;

  logic                out_free, take, empty, room_short;
  logic [CNT_W-1:0]    free_words;
  logic [WCNT_W-1:0]   in_words, hdr_words;
  logic [LEN_W-1:0]    hdr_len;
  adv_t                wp_adv_one, wp_adv_msg, rp_adv_one, rp_adv_msg;
  logic [PTR_W-1:0]    rp_inc, rp_inc2;

  lpmf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_WORDS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;
  assign empty     = !wrap_r && (wp_r == rp_r);

  assign free_words = wrap_r ? CNT_W'(rp_r) - CNT_W'(wp_r)
                             : RING_CNT - CNT_W'(wp_r) + CNT_W'(rp_r);
  assign in_words   = words_of(cmd.byte_count);
  assign room_short = (CMP_W'(in_words) + CMP_W'(1)) > CMP_W'(free_words);

  assign hdr_len    = ram_rdata[LEN_W-1:0];
  assign hdr_words  = words_of(hdr_len);

  assign wp_adv_one = ptr_adv(wp_r, (WCNT_W + 1)'(1));
  assign wp_adv_msg = ptr_adv(wp_r, (WCNT_W + 1)'(msg_words_r) + (WCNT_W + 1)'(1));
  assign rp_adv_one = ptr_adv(rp_r, (WCNT_W + 1)'(1));
  assign rp_adv_msg = ptr_adv(rp_r, (WCNT_W + 1)'(words_of(pop_len_r)) + (WCNT_W + 1)'(1));
  assign rp_inc     = ptr_inc(rp_r);
  assign rp_inc2    = ptr_inc(rp_inc);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    wrap_nxt      = wrap_r;
    left_nxt      = left_r;
    dropping_nxt  = dropping_r;
    hdr_len_nxt   = hdr_len_r;
    msg_words_nxt = msg_words_r;
    wr_pos_nxt    = wr_pos_r;
    rd_pos_nxt    = rd_pos_r;
    pop_left_nxt  = pop_left_r;
    pop_len_nxt   = pop_len_r;
    pop_cap_nxt   = pop_cap_r;
    emit          = 1'b0;
    emit_status   = ST_PUSH_OK;
    emit_word     = '0;
    emit_length   = '0;
    emit_last     = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = rp_r;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          case (cmd.kind)
            K_PUSH_FIRST: begin
              emit         = 1'b1;
              left_nxt     = '0;
              dropping_nxt = 1'b0;
              if (13'(cmd.byte_count) > MAX_LEN) begin
                emit_status = ST_PUSH_DROP;
              end else if (room_short) begin
                emit_status  = ST_PUSH_DROP;
                left_nxt     = in_words;
                dropping_nxt = (in_words != '0);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wp_r;
                ram_wdata = WORD_W'(cmd.byte_count);
                if (in_words == '0) begin
                  wp_nxt   = wp_adv_one.ptr;
                  wrap_nxt = wrap_r ^ wp_adv_one.wrapped;
                end else begin
                  left_nxt      = in_words;
                  hdr_len_nxt   = cmd.byte_count;
                  msg_words_nxt = in_words;
                  wr_pos_nxt    = ptr_inc(wp_r);
                end
              end
            end
            K_PUSH_DATA: begin
              emit = 1'b1;
              if (left_r == '0) begin
                emit_status = ST_PUSH_DROP;
              end else if (dropping_r) begin
                emit_status = ST_PUSH_DROP;
                left_nxt    = left_r - 1'b1;
                if (left_r == WCNT_W'(1)) begin
                  dropping_nxt = 1'b0;
                end
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = wr_pos_r;
                ram_wdata  = (left_r == WCNT_W'(1)) ? cmd.data_word & last_mask(hdr_len_r)
                                                    : cmd.data_word;
                wr_pos_nxt = ptr_inc(wr_pos_r);
                left_nxt   = left_r - 1'b1;
                // Commit the message on its last word
                if (left_r == WCNT_W'(1)) begin
                  wp_nxt   = wp_adv_msg.ptr;
                  wrap_nxt = wrap_r ^ wp_adv_msg.wrapped;
                end
              end
            end
            K_POP: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = ST_POP_EMPTY;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = rp_r;
                pop_cap_nxt = cmd.byte_count;
                state_nxt   = S_POP_CHK;
              end
            end
            default: begin
              emit        = 1'b1;
              emit_status = ST_PUSH_DROP;
            end
          endcase
        end
      end
      S_POP_CHK: begin
        if (pop_cap_r < hdr_len) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_POP_SMALL;
            emit_length = hdr_len;
            state_nxt   = S_IDLE;
          end
        end else if (hdr_words == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = ST_POP_DATA;
            rp_nxt      = rp_adv_one.ptr;
            wrap_nxt    = wrap_r ^ rp_adv_one.wrapped;
            state_nxt   = S_IDLE;
          end
        end else begin
          ram_re       = 1'b1;
          ram_raddr    = rp_inc;
          rd_pos_nxt   = rp_inc2;
          pop_left_nxt = hdr_words;
          pop_len_nxt  = hdr_len;
          state_nxt    = S_POP_DATA;
        end
      end
      S_POP_DATA: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_POP_DATA;
          emit_length = pop_len_r;
          if (pop_left_r == WCNT_W'(1)) begin
            emit_word = ram_rdata & last_mask(pop_len_r);
            emit_last = 1'b1;
            rp_nxt    = rp_adv_msg.ptr;
            wrap_nxt  = wrap_r ^ rp_adv_msg.wrapped;
            state_nxt = S_IDLE;
          end else begin
            emit_word    = ram_rdata;
            emit_last    = 1'b0;
            ram_re       = 1'b1;
            ram_raddr    = rd_pos_r;
            rd_pos_nxt   = ptr_inc(rd_pos_r);
            pop_left_nxt = pop_left_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      wrap_r      <= 1'b0;
      left_r      <= '0;
      dropping_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      wrap_r      <= wrap_nxt;
      left_r      <= left_nxt;
      dropping_r  <= dropping_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_len_r   <= hdr_len_nxt;
    msg_words_r <= msg_words_nxt;
    wr_pos_r    <= wr_pos_nxt;
    rd_pos_r    <= rd_pos_nxt;
    pop_left_r  <= pop_left_nxt;
    pop_len_r   <= pop_len_nxt;
    pop_cap_r   <= pop_cap_nxt;
    if (emit) begin
      out_status_r <= emit_status;
      out_word_r   <= emit_word;
      out_length_r <= emit_length;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_word      = out_word_r;
  assign out_length    = out_length_r;
  assign out_last_word = out_last_r;

endmodule

/* hw/rtl/length_prefixed_message_fifo.sv */
// Message FIFO over a ring of RING_WORDS 32-bit words. Each message is held as
// one header word (its length in bytes) and its bytes packed little-endian
// into whole words, unused high bytes zeroed. A push is a run of words: the
// first word carries the length, and the message is taken only if it is at
// most MAX_MESSAGE_BYTES long and header and payload fit in the free space,
// else its words are dropped; it becomes visible to a pop once its last word
// is stored. A pop returns the oldest message as one result word per payload
// word (one result for an empty queue, a too-small capacity or a zero-length
// message). Every push word gives one result. A pop reads and checks the
// header through the ring memory's registered read port, then streams one
// word per cycle while the result register is free. A two-deep command queue
// between the input classifier and the executing back end lets input words be
// accepted while a result waits. No clearing pass is needed.
module length_prefixed_message_fifo #(
  parameter int RING_WORDS        = 1024,
  parameter int MAX_MESSAGE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic                          in_first_beat,
  input  logic [lpmf_pkg::LEN_W-1:0]    in_byte_count,
  input  logic [lpmf_pkg::WORD_W-1:0]   in_data_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpmf_pkg::STATUS_W-1:0] out_status,
  output logic [lpmf_pkg::WORD_W-1:0]   out_word,
  output logic [lpmf_pkg::LEN_W-1:0]    out_length,
  output logic                          out_last_word
);

  import lpmf_pkg::*;

  // Classified words handed from front to back
  logic      cmd_valid;
  logic      cmd_ready;
  lpmf_cmd_t cmd;

  // Accept and classify each word, hold it in the command queue
  lpmf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_first_beat (in_first_beat),
    .in_byte_count (in_byte_count),
    .in_data_word  (in_data_word),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // Store pushes, stream pops, drive the result register
  lpmf_back #(
    .RING_WORDS        (RING_WORDS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_word      (out_word),
    .out_length    (out_length),
    .out_last_word (out_last_word)
  );

`ifndef SYNTHESIS
  // A push result is always a single, empty word
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_PUSH_OK || out_status == ST_PUSH_DROP))
      |-> (out_last_word && out_word == '0))
    else $error("push result not a single empty word");

  // Only data and capacity results report a length
  a_length_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_length != '0)
      |-> (out_status == ST_POP_DATA || out_status == ST_POP_SMALL))
    else $error("length reported on wrong status");

  // Empty and capacity failures end their run at once
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_POP_EMPTY || out_status == ST_POP_SMALL))
      |-> (out_last_word && out_word == '0))
    else $error("failed pop not a single result");

  // No stored message is longer than the limit
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (13'(out_length) <= 13'(MAX_MESSAGE_BYTES)))
    else $error("stored length beyond limit");
`endif

endmodule
